FILE: hdl/line_position_pid_drive_core_defines.svh
// Assertion macros for the line position PID drive checker.
// Expects clk and rst in the scope where a macro is used.
`ifndef LINE_POSITION_PID_DRIVE_CORE_DEFINES_SVH
`define LINE_POSITION_PID_DRIVE_CORE_DEFINES_SVH

// check outside reset
`define LPD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lpd check failed");

// check at every edge, reset included
`define LPD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("lpd check failed");

`endif

FILE: hdl/lpd_pkg.sv
// Shared types, widths and codes for the line position PID drive.
// No dependencies.
package lpd_pkg;

  localparam int SENSOR_W    = 10;
  localparam int SAMPLE_BITS = 10;
  localparam int DEN_W       = SAMPLE_BITS + 2;
  localparam int WSUM_W      = SAMPLE_BITS + 3;
  localparam int FRAC_BITS   = 8;
  localparam int QUO_W       = 10;
  localparam int STEP_W      = $clog2(QUO_W);
  localparam int ERR_W       = 12;
  localparam int SUM_W       = 24;
  localparam int DIFF_W      = ERR_W + 1;
  localparam int GAIN_W      = 16;
  localparam int DUTY_W      = 10;
  localparam int MUL_B_W     = SUM_W;
  localparam int PROD_W      = GAIN_W + MUL_B_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int Q_SHIFT     = 16;
  localparam int TURN_W      = ACC_W - Q_SHIFT;
  localparam int MOT_W       = 34;
  localparam int DUTY_MAX    = (1 << DUTY_W) - 1;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BASE_DUTY     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_TRIGGER = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_LEVEL   = 3'd5;

  localparam logic [DUTY_W-1:0] LIMIT_TRIGGER_RST = 10'd260;
  localparam logic [DUTY_W-1:0] LIMIT_LEVEL_RST   = 10'd250;

  localparam logic [1:0] MUL_SEL_P = 2'd0;
  localparam logic [1:0] MUL_SEL_I = 2'd1;
  localparam logic [1:0] MUL_SEL_D = 2'd2;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_0;
    logic [SENSOR_W-1:0] sensor_1;
    logic [SENSOR_W-1:0] sensor_2;
    logic [SENSOR_W-1:0] sensor_3;
    logic [SENSOR_W-1:0] sensor_4;
    logic [SENSOR_W-1:0] sensor_5;
  } sample_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] line_error;
    logic [DUTY_W-1:0]       right_duty;
    logic                    right_reverse;
    logic [DUTY_W-1:0]       left_duty;
    logic                    left_reverse;
  } drive_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [DUTY_W-1:0]        base_duty;
    logic [DUTY_W-1:0]        limit_trigger;
    logic [DUTY_W-1:0]        limit_level;
  } cfg_t;

  typedef struct packed {
    logic       capture;
    logic       div_load;
    logic       div_half;
    logic       div_step;
    logic       rmag_store;
    logic       err_store;
    logic       integ;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_clr;
    logic       acc_add;
    logic       mix;
    logic       lim_pos;
    logic       lim_neg;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

FILE: hdl/lpd_regs.sv
// APB-style configuration registers for the line position PID drive.
// Depends on lpd_pkg.
module lpd_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [lpd_pkg::ADDR_W-1:0] paddr,
  input  logic [lpd_pkg::DATA_W-1:0] pwdata,
  output logic [lpd_pkg::DATA_W-1:0] prdata,
  output logic                  pready,
  output lpd_pkg::cfg_t         cfg
);
  import lpd_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p        <= '0;
      cfg.gain_i        <= '0;
      cfg.gain_d        <= '0;
      cfg.base_duty     <= '0;
      cfg.limit_trigger <= LIMIT_TRIGGER_RST;
      cfg.limit_level   <= LIMIT_LEVEL_RST;
    end else if (wr) begin
      unique case (idx)
        REG_GAIN_P:        cfg.gain_p        <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:        cfg.gain_i        <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:        cfg.gain_d        <= pwdata[GAIN_W-1:0];
        REG_BASE_DUTY:     cfg.base_duty     <= pwdata[DUTY_W-1:0];
        REG_LIMIT_TRIGGER: cfg.limit_trigger <= pwdata[DUTY_W-1:0];
        REG_LIMIT_LEVEL:   cfg.limit_level   <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_GAIN_P:        prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg.gain_p};
      REG_GAIN_I:        prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg.gain_i};
      REG_GAIN_D:        prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg.gain_d};
      REG_BASE_DUTY:     prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg.base_duty};
      REG_LIMIT_TRIGGER: prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg.limit_trigger};
      REG_LIMIT_LEVEL:   prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg.limit_level};
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: hdl/lpd_div.sv
// Restoring divider for the centroid: (wsum << 8) / den, one quotient bit a cycle while step is high.
// Depends on lpd_pkg. The quotient is below 1024 since wsum never exceeds 3*den.
module lpd_div (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         step,
  input  logic [lpd_pkg::WSUM_W-1:0]   wsum,
  input  logic [lpd_pkg::DEN_W-1:0]    den,
  output logic [lpd_pkg::QUO_W-1:0]    quot
);
  import lpd_pkg::*;

  localparam int NUM_W = WSUM_W + FRAC_BITS;

  logic [NUM_W-1:0] numer;
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;

  assign numer   = {wsum, {FRAC_BITS{1'b0}}};
  assign shifted = {rem, q[QUO_W-1]};
  assign trial   = shifted - {1'b0, den};
  assign quot    = q;

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= DEN_W'(numer[NUM_W-1:QUO_W]);
      q   <= numer[QUO_W-1:0];
    end else if (step) begin
      if (shifted >= {1'b0, den}) begin
        rem <= trial[DEN_W-1:0];
        q   <= {q[QUO_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DEN_W-1:0];
        q   <= {q[QUO_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: hdl/lpd_dp.sv
// Datapath: sample capture, centroid divider, PID multiply-accumulate,
// motor mixing with excess transfer and the output register. Depends on lpd_pkg, lpd_div.
module lpd_dp (
  input  logic              clk,
  input  logic              rst,
  input  lpd_pkg::cmd_t     cmd,
  output lpd_pkg::status_t  status,
  input  lpd_pkg::cfg_t     cfg,
  input  lpd_pkg::sample_t  sample,
  output logic              drive_valid,
  input  logic              drive_ready,
  output lpd_pkg::drive_t   drive
);
  import lpd_pkg::*;

  logic [SAMPLE_BITS-1:0] s0, s1, s2, s3, s4, s5;
  logic [WSUM_W-1:0]      wsum;
  logic [DEN_W-1:0]       den;
  logic [QUO_W-1:0]       quot;
  logic [QUO_W-1:0]       rmag;
  logic [QUO_W-1:0]       lmag;
  logic                   dz;

  logic signed [ERR_W-1:0]   err_q;
  logic signed [ERR_W-1:0]   last_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_next;

  logic signed [GAIN_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [TURN_W-1:0]  turn;
  logic signed [MOT_W-1:0]   turn_ext;

  logic signed [MOT_W-1:0] right_q, left_q;
  logic signed [MOT_W-1:0] base_s, trig_s, lvl_s;

  function automatic logic [DUTY_W-1:0] duty_of(input logic signed [MOT_W-1:0] v);
    logic [MOT_W-1:0] a;
    a = (v < 0) ? MOT_W'(-v) : MOT_W'(v);
    if (a > MOT_W'(DUTY_MAX)) return DUTY_W'(DUTY_MAX);
    return a[DUTY_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s0 <= SAMPLE_BITS'(sample.sensor_0);
      s1 <= SAMPLE_BITS'(sample.sensor_1);
      s2 <= SAMPLE_BITS'(sample.sensor_2);
      s3 <= SAMPLE_BITS'(sample.sensor_3);
      s4 <= SAMPLE_BITS'(sample.sensor_4);
      s5 <= SAMPLE_BITS'(sample.sensor_5);
    end
  end

  always_comb begin
    if (cmd.div_half) begin
      wsum = WSUM_W'(s3) + WSUM_W'({s4, 1'b0}) + WSUM_W'({s5, 1'b0}) + WSUM_W'(s5);
      den  = DEN_W'(s3) + DEN_W'(s4) + DEN_W'(s5);
    end else begin
      wsum = WSUM_W'({s0, 1'b0}) + WSUM_W'(s0) + WSUM_W'({s1, 1'b0}) + WSUM_W'(s2);
      den  = DEN_W'(s0) + DEN_W'(s1) + DEN_W'(s2);
    end
  end

  lpd_div u_div (
    .clk  (clk),
    .load (cmd.div_load),
    .step (cmd.div_step),
    .wsum (wsum),
    .den  (den),
    .quot (quot)
  );

  assign lmag = dz ? '0 : quot;

  always_ff @(posedge clk) begin
    if (cmd.div_load) dz <= (den == '0);
    if (cmd.rmag_store) rmag <= lmag;
    if (cmd.err_store) err_q <= ERR_W'(0) - ERR_W'(rmag) - ERR_W'(lmag);
  end

  // integral with saturation on overflow
  assign sum_wide = sum_q + err_q;
  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_q  <= '0;
      last_q <= '0;
    end else if (cmd.integ) begin
      sum_q  <= sum_next;
      last_q <= err_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.integ) diff_q <= DIFF_W'(err_q) - DIFF_W'(last_q);
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_SEL_P: begin
        mul_a = cfg.gain_p;
        mul_b = MUL_B_W'(err_q);
      end
      MUL_SEL_I: begin
        mul_a = cfg.gain_i;
        mul_b = sum_q;
      end
      MUL_SEL_D: begin
        mul_a = cfg.gain_d;
        mul_b = MUL_B_W'(diff_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_q <= mul_a * mul_b;
    if (cmd.acc_clr) acc_q <= '0;
    else if (cmd.acc_add) acc_q <= acc_q + ACC_W'(prod_q);
  end

  // floor division by 65536 is an arithmetic shift
  assign turn     = acc_q[ACC_W-1:Q_SHIFT];
  assign turn_ext = MOT_W'(turn);
  assign base_s   = MOT_W'(cfg.base_duty);
  assign trig_s   = MOT_W'(cfg.limit_trigger);
  assign lvl_s    = MOT_W'(cfg.limit_level);

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      right_q <= base_s - turn_ext;
      left_q  <= base_s + turn_ext;
    end else if (cmd.lim_pos) begin
      if (right_q > trig_s) begin
        right_q <= lvl_s;
        left_q  <= left_q - (right_q - lvl_s);
      end else if (left_q > trig_s) begin
        left_q  <= lvl_s;
        right_q <= right_q - (left_q - lvl_s);
      end
    end else if (cmd.lim_neg) begin
      if (right_q < -trig_s) begin
        right_q <= -lvl_s;
        left_q  <= left_q + (-right_q - lvl_s);
      end else if (left_q < -trig_s) begin
        left_q  <= -lvl_s;
        right_q <= right_q + (-left_q - lvl_s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      drive.line_error    <= err_q;
      drive.right_duty    <= duty_of(right_q);
      drive.right_reverse <= right_q[MOT_W-1];
      drive.left_duty     <= duty_of(left_q);
      drive.left_reverse  <= left_q[MOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (cmd.out_load) begin
      drive_valid <= 1'b1;
    end else if (drive_ready) begin
      drive_valid <= 1'b0;
    end
  end

  assign status.out_free = !drive_valid || drive_ready;

endmodule

FILE: hdl/lpd_ctrl.sv
// Sequencer for the line position PID drive: steps the datapath through
// capture, two centroid divisions, PID, mixing, limiting and output. Depends on lpd_pkg.
module lpd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  lpd_pkg::status_t  status,
  output lpd_pkg::cmd_t     cmd
);
  import lpd_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LOAD_R = 4'd1;
  localparam logic [3:0] ST_DIV_R  = 4'd2;
  localparam logic [3:0] ST_LOAD_L = 4'd3;
  localparam logic [3:0] ST_DIV_L  = 4'd4;
  localparam logic [3:0] ST_ERR    = 4'd5;
  localparam logic [3:0] ST_INTEG  = 4'd6;
  localparam logic [3:0] ST_MUL_P  = 4'd7;
  localparam logic [3:0] ST_MUL_I  = 4'd8;
  localparam logic [3:0] ST_MUL_D  = 4'd9;
  localparam logic [3:0] ST_ACC    = 4'd10;
  localparam logic [3:0] ST_MIX    = 4'd11;
  localparam logic [3:0] ST_LIM_P  = 4'd12;
  localparam logic [3:0] ST_LIM_N  = 4'd13;
  localparam logic [3:0] ST_OUT    = 4'd14;

  logic [3:0]        state, state_next;
  logic [STEP_W-1:0] cnt;
  logic              last_step;

  assign last_step = (cnt == STEP_W'(QUO_W - 1));

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD_R;
        end
      end
      ST_LOAD_R: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV_R;
      end
      ST_DIV_R: begin
        cmd.div_step = 1'b1;
        if (last_step) state_next = ST_LOAD_L;
      end
      ST_LOAD_L: begin
        cmd.rmag_store = 1'b1;
        cmd.div_load   = 1'b1;
        cmd.div_half   = 1'b1;
        state_next     = ST_DIV_L;
      end
      ST_DIV_L: begin
        cmd.div_half = 1'b1;
        cmd.div_step = 1'b1;
        if (last_step) state_next = ST_ERR;
      end
      ST_ERR: begin
        cmd.err_store = 1'b1;
        state_next    = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ  = 1'b1;
        state_next = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SEL_P;
        cmd.acc_clr = 1'b1;
        state_next  = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SEL_I;
        cmd.acc_add = 1'b1;
        state_next  = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SEL_D;
        cmd.acc_add = 1'b1;
        state_next  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix    = 1'b1;
        state_next = ST_LIM_P;
      end
      ST_LIM_P: begin
        cmd.lim_pos = 1'b1;
        state_next  = ST_LIM_N;
      end
      ST_LIM_N: begin
        cmd.lim_neg = 1'b1;
        state_next  = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cmd.div_step ? cnt + STEP_W'(1) : '0;
    end
  end

endmodule

FILE: hdl/line_position_pid_drive_core.sv
// Line position PID drive, top level. Depends on lpd_pkg, lpd_regs,
// lpd_ctrl, lpd_dp.
// Usage: a word on the sample channel (valid/ready) carries six sensor
// samples. The block forms the left and right centroids, the line error,
// a PID turn value and two motor drive values, and presents one word on
// the drive channel (valid/ready) with the error, duties and directions.
// Gains, base duty and limit settings are to be written over the APB-style
// port only while the block is idle, which the block does not enforce;
// pready is always high. A new sample word is taken only in the idle state;
// the two 10-step centroid divisions go through one shared restoring
// divider and the three passes of the PID terms through one multiplier.
// Reset: synchronous, clears the integral, the previous error, the
// registers to their defaults and the output valid.
// Stall: a finished word waits in the output register; a following sample
// is still taken and processed, and its result holds in the last step until
// the output register is free.
module line_position_pid_drive_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  lpd_pkg::sample_t           sample,
  output logic                       drive_valid,
  input  logic                       drive_ready,
  output lpd_pkg::drive_t            drive,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lpd_pkg::ADDR_W-1:0] paddr,
  input  logic [lpd_pkg::DATA_W-1:0] pwdata,
  output logic [lpd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import lpd_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  lpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  lpd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg         (cfg),
    .sample      (sample),
    .drive_valid (drive_valid),
    .drive_ready (drive_ready),
    .drive       (drive)
  );

endmodule

FILE: hdl/lpd_checker.sv
// Port-level checks for the line position PID drive, bound to the top level.
// Depends on lpd_pkg and line_position_pid_drive_core_defines.svh.
`include "line_position_pid_drive_core_defines.svh"

module lpd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       sample_valid,
  input logic                       sample_ready,
  input logic                       drive_valid,
  input logic                       drive_ready,
  input lpd_pkg::drive_t            drive,
  input logic                       pready
);
  import lpd_pkg::*;

  `LPD_ASSERT_ALWAYS(a_pready_high, pready)
  `LPD_ASSERT(a_one_at_a_time, sample_valid && sample_ready |=> !sample_ready)
  `LPD_ASSERT(a_error_not_positive, drive_valid |-> drive.line_error <= 0)
  `LPD_ASSERT(a_stall_holds, drive_valid && !drive_ready |=> drive_valid && $stable(drive))

endmodule

bind line_position_pid_drive_core lpd_checker u_lpd_checker (.*);

FILE: bench/line_position_pid_drive_core_tb.sv
// Self-checking bench for line_position_pid_drive_core: sample words in, drive words out,
// register setup over the APB-style port, results checked against an in-bench predictor.
// Depends on lpd_pkg and the core RTL.
module line_position_pid_drive_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpd_pkg::*;

  localparam int     CYCLE_LIMIT = 4000000;
  localparam int     GAP_MAX     = 18;
  localparam longint INTEG_HI    = 64'sd8388607;
  localparam longint INTEG_LO    = -64'sd8388608;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic              clk;
  logic              rst;
  logic              sample_valid;
  logic              sample_ready;
  sample_t           sample;
  logic              drive_valid;
  logic              drive_ready;
  drive_t            drive;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // register mirror and loop state of the predictor
  longint cfg_gain_p, cfg_gain_i, cfg_gain_d;
  longint cfg_base, cfg_trigger, cfg_level;
  longint err_sum, prev_err;

  drive_t expected_drive[$];
  drive_t exp_word;

  int send_gap_max, ready_gap_max;
  int sent_count, drive_count, write_count;
  int mismatch_count, unexpected_count, leftover_count;
  longint cycle_count;

  line_position_pid_drive_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .drive_valid  (drive_valid),
    .drive_ready  (drive_ready),
    .drive        (drive),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint abs_val(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [DUTY_W-1:0] duty_mag(longint v);
    longint a;
    a = abs_val(v);
    return (a > DUTY_MAX) ? DUTY_MAX[DUTY_W-1:0] : a[DUTY_W-1:0];
  endfunction

  function automatic drive_t predict_drive(sample_t s);
    longint smask, r0, r1, r2, l0, l1, l2, rden, lden, rcen, lcen;
    longint err, acc, turn, rmot, lmot, excess;
    drive_t d;
    smask = (64'sd1 <<< SAMPLE_BITS) - 1;
    r0 = s.sensor_0 & smask;
    r1 = s.sensor_1 & smask;
    r2 = s.sensor_2 & smask;
    l0 = s.sensor_3 & smask;
    l1 = s.sensor_4 & smask;
    l2 = s.sensor_5 & smask;
    rden = r0 + r1 + r2;
    lden = l0 + l1 + l2;
    rcen = (rden == 0) ? 0 : -(((3 * r0 + 2 * r1 + r2) * 256) / rden);
    lcen = (lden == 0) ? 0 : (((l0 + 2 * l1 + 3 * l2) * 256) / lden);
    err = rcen - lcen;
    err_sum = err_sum + err;
    if (err_sum > INTEG_HI) err_sum = INTEG_HI;
    if (err_sum < INTEG_LO) err_sum = INTEG_LO;
    acc = cfg_gain_p * err + cfg_gain_i * err_sum + cfg_gain_d * (err - prev_err);
    prev_err = err;
    turn = acc >>> Q_SHIFT;
    rmot = cfg_base - turn;
    lmot = cfg_base + turn;
    if (rmot > cfg_trigger) begin
      excess = abs_val(rmot) - cfg_level;
      rmot = cfg_level;
      lmot = lmot - excess;
    end else if (lmot > cfg_trigger) begin
      excess = abs_val(lmot) - cfg_level;
      lmot = cfg_level;
      rmot = rmot - excess;
    end
    if (rmot < -cfg_trigger) begin
      excess = abs_val(rmot) - cfg_level;
      rmot = -cfg_level;
      lmot = lmot + excess;
    end else if (lmot < -cfg_trigger) begin
      excess = abs_val(lmot) - cfg_level;
      lmot = -cfg_level;
      rmot = rmot + excess;
    end
    d.line_error    = err[ERR_W-1:0];
    d.right_duty    = duty_mag(rmot);
    d.right_reverse = (rmot < 0);
    d.left_duty     = duty_mag(lmot);
    d.left_reverse  = (lmot < 0);
    return d;
  endfunction

  function automatic sample_t make_sample(int a, int b, int c, int d, int e, int f);
    sample_t s;
    s.sensor_0 = a[SENSOR_W-1:0];
    s.sensor_1 = b[SENSOR_W-1:0];
    s.sensor_2 = c[SENSOR_W-1:0];
    s.sensor_3 = d[SENSOR_W-1:0];
    s.sensor_4 = e[SENSOR_W-1:0];
    s.sensor_5 = f[SENSOR_W-1:0];
    return s;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s = sample_t'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: {s.sensor_0, s.sensor_1, s.sensor_2} = '0;
      1: {s.sensor_3, s.sensor_4, s.sensor_5} = '0;
      2: s = '0;
      3: s = make_sample($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                         $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain(int mag);
    int v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = $urandom;
      2: v = $urandom_range(0, 1) ? 32'h7fff : 32'h8000;
      default: v = int'($urandom_range(0, 2 * mag)) - mag;
    endcase
    return {16'($urandom_range(0, 16'hffff)), v[15:0]};
  endfunction

  function automatic logic [DATA_W-1:0] pick_duty();
    int v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = DUTY_MAX;
      default: v = $urandom_range(0, DUTY_MAX);
    endcase
    return {22'($urandom_range(0, 22'h3fffff)), v[DUTY_W-1:0]};
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd;
    logic              bad;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_GAIN_P:        cfg_gain_p  = $signed(value[GAIN_W-1:0]);
      REG_GAIN_I:        cfg_gain_i  = $signed(value[GAIN_W-1:0]);
      REG_GAIN_D:        cfg_gain_d  = $signed(value[GAIN_W-1:0]);
      REG_BASE_DUTY:     cfg_base    = value[DUTY_W-1:0];
      REG_LIMIT_TRIGGER: cfg_trigger = value[DUTY_W-1:0];
      REG_LIMIT_LEVEL:   cfg_level   = value[DUTY_W-1:0];
      default: ;
    endcase
    write_count++;
    // read back
    psel = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    case (idx)
      REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: bad = (rd[GAIN_W-1:0] !== value[GAIN_W-1:0]);
      REG_BASE_DUTY, REG_LIMIT_TRIGGER, REG_LIMIT_LEVEL:
        bad = (rd[DUTY_W-1:0] !== value[DUTY_W-1:0]);
      default: bad = 1'b0;
    endcase
    if (bad) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("readback mismatch reg %0d: expected %h actual %h", idx, value, rd);
    end
  endtask

  task automatic write_all(input logic [DATA_W-1:0] gp, input logic [DATA_W-1:0] gi,
                           input logic [DATA_W-1:0] gd, input logic [DATA_W-1:0] base,
                           input logic [DATA_W-1:0] trig, input logic [DATA_W-1:0] lvl);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_BASE_DUTY, base);
    write_reg(REG_LIMIT_TRIGGER, trig);
    write_reg(REG_LIMIT_LEVEL, lvl);
  endtask

  task automatic send_sample(input sample_t s);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample       = s;
    sample_valid = 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    expected_drive.push_back(predict_drive(s));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    sample_valid = 1'b0;
    while (expected_drive.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic test_directed();
    sample_t pats[$];
    pats.push_back(make_sample(0, 0, 0, 0, 0, 0));
    pats.push_back(make_sample(1023, 1023, 1023, 1023, 1023, 1023));
    pats.push_back(make_sample(0, 0, 0, 1023, 1023, 1023));
    pats.push_back(make_sample(1023, 1023, 1023, 0, 0, 0));
    pats.push_back(make_sample(1023, 0, 0, 0, 0, 0));
    pats.push_back(make_sample(0, 1023, 0, 0, 0, 0));
    pats.push_back(make_sample(0, 0, 1023, 0, 0, 0));
    pats.push_back(make_sample(0, 0, 0, 1023, 0, 0));
    pats.push_back(make_sample(0, 0, 0, 0, 1023, 0));
    pats.push_back(make_sample(0, 0, 0, 0, 0, 1023));
    pats.push_back(make_sample(1, 0, 0, 0, 0, 1));
    pats.push_back(make_sample(0, 0, 1, 1, 0, 0));
    pats.push_back(make_sample('h2aa, 'h155, 'h2aa, 'h155, 'h2aa, 'h155));
    pats.push_back(make_sample('h155, 'h2aa, 'h155, 'h2aa, 'h155, 'h2aa));
    send_gap_max  = GAP_MAX;
    ready_gap_max = GAP_MAX;
    // reset defaults first
    for (int i = 0; i < 4; i++) send_sample(pats[i]);
    wait_drained();
    write_all(32'h0000_0100, 32'h0000_0010, 32'h0000_0080, 32'd300, 32'd260, 32'd250);
    foreach (pats[i]) send_sample(pats[i]);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_all(32'h0000_7fff, 32'h0000_7fff, 32'h0000_7fff, 32'd1023, 32'd1023, 32'd1023);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    send_sample(make_sample(1023, 0, 0, 0, 0, 1023));
    send_sample(rand_sample());
    wait_drained();
    write_all(32'hffff_8000, 32'hffff_8000, 32'hffff_8000, 32'd0, 32'd0, 32'd0);
    send_sample(make_sample(0, 0, 1023, 1023, 0, 0));
    send_sample(rand_sample());
    wait_drained();
    write_all(32'hffff_8000, 32'h0000_0000, 32'h0000_7fff, 32'd1023, 32'd0, 32'd1023);
    send_sample(make_sample(1023, 1023, 1023, 1023, 1023, 1023));
    send_sample(make_sample(0, 0, 0, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 11; phase++) begin
      wait_drained();
      write_all(pick_gain(16384), pick_gain(96), pick_gain(16384),
                pick_duty(), pick_duty(), pick_duty());
      send_gap_max  = (phase % 4 == 0 || phase == 5) ? 0 : GAP_MAX;
      ready_gap_max = (phase % 4 == 0 || phase == 7) ? 0 : GAP_MAX;
      for (int i = 0; i < 90; i++) begin
        // hold off until the pipe empties
        if (i == 50 && phase % 2 == 1) wait_drained();
        send_sample(rand_sample());
      end
    end
    wait_drained();
  endtask

  task automatic test_integral_windup();
    send_gap_max  = 0;
    ready_gap_max = 0;
    write_all(32'h0000_0001, 32'h0000_4000, 32'h0000_0000, 32'd400, 32'd260, 32'd250);
    for (int i = 0; i < 40; i++)
      send_sample(make_sample($urandom_range(1, 1023), 0, 0, 0, 0, $urandom_range(1, 1023)));
    for (int i = 0; i < 16; i++) send_sample(rand_sample());
    wait_drained();
    send_gap_max  = GAP_MAX;
    ready_gap_max = GAP_MAX;
    write_all(pick_gain(16384), pick_gain(96), pick_gain(16384),
              pick_duty(), pick_duty(), pick_duty());
    for (int i = 0; i < 30; i++) send_sample(rand_sample());
    wait_drained();
  endtask

  // drive channel sink with random stalls
  initial begin
    int gap;
    drive_ready = 1'b0;
    forever begin
      gap = $urandom_range(0, ready_gap_max);
      if (gap > 0) begin
        drive_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      drive_ready = 1'b1;
      @(posedge clk);
      while (!drive_valid || rst) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && drive_valid && drive_ready) begin
      drive_count++;
      if (expected_drive.size() == 0) begin
        unexpected_count++;
        if (unexpected_count + mismatch_count <= 10)
          $display("unexpected drive word %p", drive);
      end else begin
        exp_word = expected_drive.pop_front();
        if (drive.line_error !== exp_word.line_error ||
            drive.right_duty !== exp_word.right_duty ||
            drive.right_reverse !== exp_word.right_reverse ||
            drive.left_duty !== exp_word.left_duty ||
            drive.left_reverse !== exp_word.left_reverse) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("drive mismatch word %0d: expected %p actual %p",
                     drive_count, exp_word, drive);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    sample_valid  = 1'b0;
    sample        = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_gap_max  = GAP_MAX;
    ready_gap_max = GAP_MAX;
    cfg_gain_p    = 0;
    cfg_gain_i    = 0;
    cfg_gain_d    = 0;
    cfg_base      = 0;
    cfg_trigger   = LIMIT_TRIGGER_RST;
    cfg_level     = LIMIT_LEVEL_RST;
    err_sum       = 0;
    prev_err      = 0;
    sent_count    = 0;
    drive_count   = 0;
    write_count   = 0;
    mismatch_count   = 0;
    unexpected_count = 0;
    leftover_count   = 0;
    cycle_count   = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_config_extremes();
    test_random();
    test_integral_windup();
    wait_drained();
    repeat (40) @(negedge clk);
    leftover_count = expected_drive.size();
    $display("run covered %0d sample words and %0d drive words over %0d register writes,",
             sent_count, drive_count, write_count);
    $display("centroid corners, gain extremes, stalls and integral windup; %0d mismatches, %0d strays",
             mismatch_count, unexpected_count + leftover_count);
    if (mismatch_count == 0 && unexpected_count == 0 && leftover_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
